// ===== src/scaled_decimal_compare_unit_macros.svh =====
// Assertion macros shared by the compare unit modules
`ifndef SCALED_DECIMAL_COMPARE_UNIT_MACROS_SVH
`define SCALED_DECIMAL_COMPARE_UNIT_MACROS_SVH

// Implication checked at every edge outside reset
`define SDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sdc_pkg.sv =====
// Package: types, constants and helpers of the scaled decimal compare unit
`default_nettype none
package sdc_pkg;
    localparam int MAX_SCALE_DEF = 28;
    localparam int MANTISSA_WORDS_DEF = 3;
    localparam int MANT_W = 96;
    localparam int WIDE_W = 224;
    localparam int SCALE_W = 5;
    localparam int POW_W = 96;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_LT = 3'd0,
        OP_LE = 3'd1,
        OP_GT = 3'd2,
        OP_GE = 3'd3,
        OP_EQ = 3'd4,
        OP_NE = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]        op;
        logic              sign_decided;
        logic              sign_rel_neg;
        logic              both_neg;
        logic              swap;
        logic [MANT_W-1:0] small_m;
        logic [MANT_W-1:0] large_m;
        logic [SCALE_W-1:0] diff;
    } work_t;

    function automatic logic [POW_W-1:0] pow10(input logic [SCALE_W-1:0] e);
        logic [POW_W-1:0] p;
        case (e)
            5'd0: p = 96'd1;
            5'd1: p = 96'd10;
            5'd2: p = 96'd100;
            5'd3: p = 96'd1_000;
            5'd4: p = 96'd10_000;
            5'd5: p = 96'd100_000;
            5'd6: p = 96'd1_000_000;
            5'd7: p = 96'd10_000_000;
            5'd8: p = 96'd100_000_000;
            5'd9: p = 96'd1_000_000_000;
            5'd10: p = 96'd10_000_000_000;
            5'd11: p = 96'd100_000_000_000;
            5'd12: p = 96'd1_000_000_000_000;
            5'd13: p = 96'd10_000_000_000_000;
            5'd14: p = 96'd100_000_000_000_000;
            5'd15: p = 96'd1_000_000_000_000_000;
            5'd16: p = 96'd10_000_000_000_000_000;
            5'd17: p = 96'd100_000_000_000_000_000;
            5'd18: p = 96'd1_000_000_000_000_000_000;
            5'd19: p = 96'd10_000_000_000_000_000_000;
            5'd20: p = 96'd100_000_000_000_000_000_000;
            5'd21: p = 96'd1_000_000_000_000_000_000_000;
            5'd22: p = 96'd10_000_000_000_000_000_000_000;
            5'd23: p = 96'd100_000_000_000_000_000_000_000;
            5'd24: p = 96'd1_000_000_000_000_000_000_000_000;
            5'd25: p = 96'd10_000_000_000_000_000_000_000_000;
            5'd26: p = 96'd100_000_000_000_000_000_000_000_000;
            5'd27: p = 96'd1_000_000_000_000_000_000_000_000_000;
            5'd28: p = 96'd10_000_000_000_000_000_000_000_000_000;
            default: p = 96'd1;
        endcase
        return p;
    endfunction
endpackage
`default_nettype wire

// ===== src/sdc_if.sv =====
// Valid/ready channel interface
`default_nettype none
interface sdc_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/sdc_front.sv =====
// Front part: clamp scales, resolve signs, pick operand to scale
`default_nettype none
module sdc_front #(
    parameter int MAX_SCALE = sdc_pkg::MAX_SCALE_DEF,
    parameter int MANTISSA_WORDS = sdc_pkg::MANTISSA_WORDS_DEF
) (
    input  wire logic [2:0]               op,
    input  wire logic [sdc_pkg::MANT_W-1:0] a_m,
    input  wire logic [4:0]               a_scale,
    input  wire logic                     a_negative,
    input  wire logic [sdc_pkg::MANT_W-1:0] b_m,
    input  wire logic [4:0]               b_scale,
    input  wire logic                     b_negative,
    output sdc_pkg::work_t                work
);
    localparam int KEEP = 32 * MANTISSA_WORDS;
    localparam logic [sdc_pkg::MANT_W-1:0] MASK = (sdc_pkg::MANT_W)'({KEEP{1'b1}});
    logic [sdc_pkg::MANT_W-1:0] ma, mb;
    logic [4:0] sa, sb;
    logic na, nb;
    always_comb
    begin
        ma = a_m & MASK;
        mb = b_m & MASK;
        sa = (a_scale > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : a_scale;
        sb = (b_scale > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : b_scale;
        na = a_negative && (ma != '0);
        nb = b_negative && (mb != '0);
        work.op = op;
        work.sign_decided = (na != nb);
        work.sign_rel_neg = na;
        work.both_neg = na;
        work.swap = (sb < sa);
        work.small_m = (sb < sa) ? mb : ma;
        work.large_m = (sb < sa) ? ma : mb;
        work.diff = (sb < sa) ? (sa - sb) : (sb - sa);
    end
endmodule
`default_nettype wire

// ===== src/sdc_queue.sv =====
// Two-entry queue between the front and back parts
`default_nettype none
module sdc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sdc_pkg::work_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sdc_pkg::work_t      out_data
);
    `include "scaled_decimal_compare_unit_macros.svh"
    sdc_pkg::work_t mem [sdc_pkg::QUEUE_DEPTH];
    logic wr_reg, rd_reg;
    logic [1:0] count_reg;
    logic push, pop;
    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_data = mem[rd_reg];
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_data;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
    `SDC_ASSERT_IMPL(a_q_count, clk, rst_n, 1'b1, count_reg <= 2'd2, "queue overflow")
    `SDC_ASSERT_NEXT(a_q_full, clk, rst_n, push && !pop && count_reg == 2'd1,
        count_reg == 2'd2, "queue count lost")
    `SDC_ASSERT_IMPL(a_q_ptr, clk, rst_n, count_reg == 2'd0 || count_reg == 2'd2,
        wr_reg == rd_reg, "queue pointers out of step")
endmodule
`default_nettype wire

// ===== src/sdc_back.sv =====
// Back part: pipelined scale multiply, magnitude compare, relation select
`default_nettype none
module sdc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sdc_pkg::work_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                holds
);
    `include "scaled_decimal_compare_unit_macros.svh"
    // stage 1: power of ten; stage 2: 32x32 partial products; stage 3: sum;
    // stage 4: compare and select into the output register
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic adv;
    sdc_pkg::work_t w1_reg;
    logic [sdc_pkg::POW_W-1:0] p1_reg;
    logic [2:0] op2_reg, op3_reg;
    logic dec2_reg, neg2_reg, bn2_reg, sw2_reg;
    logic dec3_reg, neg3_reg, bn3_reg, sw3_reg;
    logic [sdc_pkg::MANT_W-1:0] lg2_reg;
    logic [sdc_pkg::WIDE_W-1:0] lg3_reg, sc3_reg;
    logic [63:0] pp_reg [3][3];
    logic [sdc_pkg::WIDE_W-1:0] sum;
    logic rel_lt, rel_gt, res;
    logic holds_reg;

    assign adv = !vo_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = vo_reg;
    assign holds = holds_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum = sum + (sdc_pkg::WIDE_W'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_comb
    begin
        logic mlt, mgt;
        if (sw3_reg)
        begin
            mlt = lg3_reg < sc3_reg;
            mgt = lg3_reg > sc3_reg;
        end
        else
        begin
            mlt = sc3_reg < lg3_reg;
            mgt = sc3_reg > lg3_reg;
        end
        if (dec3_reg)
        begin
            rel_lt = neg3_reg;
            rel_gt = !neg3_reg;
        end
        else
        begin
            rel_lt = bn3_reg ? mgt : mlt;
            rel_gt = bn3_reg ? mlt : mgt;
        end
        case (op3_reg)
            sdc_pkg::OP_LT: res = rel_lt;
            sdc_pkg::OP_LE: res = !rel_gt;
            sdc_pkg::OP_GT: res = rel_gt;
            sdc_pkg::OP_GE: res = !rel_lt;
            sdc_pkg::OP_EQ: res = !rel_lt && !rel_gt;
            sdc_pkg::OP_NE: res = rel_lt || rel_gt;
            default: res = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg <= in_data;
            p1_reg <= sdc_pkg::pow10(in_data.diff);
            op2_reg <= w1_reg.op;
            dec2_reg <= w1_reg.sign_decided;
            neg2_reg <= w1_reg.sign_rel_neg;
            bn2_reg <= w1_reg.both_neg;
            sw2_reg <= w1_reg.swap;
            lg2_reg <= w1_reg.large_m;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pp_reg[i][j] <= 64'(w1_reg.small_m[32*i +: 32]) * 64'(p1_reg[32*j +: 32]);
                end
            end
            op3_reg <= op2_reg;
            dec3_reg <= dec2_reg;
            neg3_reg <= neg2_reg;
            bn3_reg <= bn2_reg;
            sw3_reg <= sw2_reg;
            lg3_reg <= sdc_pkg::WIDE_W'(lg2_reg);
            sc3_reg <= sum;
            holds_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    `SDC_ASSERT_NEXT(a_b_hold, clk, rst_n, vo_reg && !out_ready,
        vo_reg && $stable(holds_reg), "result dropped while stalled")
    `SDC_ASSERT_NEXT(a_b_adv, clk, rst_n, adv && v3_reg, vo_reg, "stage 3 item lost")
    `SDC_ASSERT_IMPL(a_b_dec, clk, rst_n, v3_reg && dec3_reg,
        rel_lt != rel_gt, "sign-decided item compares equal")
endmodule
`default_nettype wire

// ===== src/scaled_decimal_compare_unit.sv =====
// Top level of the scaled decimal compare unit
// channel | role   | payload
// in_ch   | sink   | op, a/b mantissa low/high, scale, negative
// out_ch  | source | holds
// One pair accepted per cycle while out_ch is not stalled; results pass through the queue and back registers.
// The back part is a four-register pipeline around a 96x96 multiply split
// into nine 32x32 partial products. A two-entry queue decouples front and back.
// Reset clears all valid bits asynchronously; a stalled output freezes the back
// part and the queue then fills and drops in_ch.ready.
`default_nettype none
module scaled_decimal_compare_unit #(
    parameter int MAX_SCALE = sdc_pkg::MAX_SCALE_DEF,
    parameter int MANTISSA_WORDS = sdc_pkg::MANTISSA_WORDS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    sdc_if.sink      in_ch,
    sdc_if.source    out_ch
);
    sdc_pkg::work_t fw, qd;
    logic qv, qr;
    sdc_front #(.MAX_SCALE(MAX_SCALE), .MANTISSA_WORDS(MANTISSA_WORDS)) u_front (
        .op(in_ch.data.op),
        .a_m({in_ch.data.a_mantissa_high, in_ch.data.a_mantissa_low}),
        .a_scale(in_ch.data.a_scale),
        .a_negative(in_ch.data.a_negative),
        .b_m({in_ch.data.b_mantissa_high, in_ch.data.b_mantissa_low}),
        .b_scale(in_ch.data.b_scale),
        .b_negative(in_ch.data.b_negative),
        .work(fw)
    );
    sdc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(fw),
        .out_valid(qv), .out_ready(qr), .out_data(qd)
    );
    sdc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_data(qd),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .holds(out_ch.data.holds)
    );
endmodule
`default_nettype wire
